### sv/sensor_wrap_unwrap_assert.svh
// Assertion macros shared by the sensor wrap/unwrap checker.
// No dependencies; included by sv/swu_checker.sv.
`ifndef SENSOR_WRAP_UNWRAP_ASSERT_SVH
`define SENSOR_WRAP_UNWRAP_ASSERT_SVH

// Same-cycle implication, gated off while rst_expr is high.
`define SWU_ASSERT_IMP(label, clk_sig, rst_expr, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_expr) (ante) |-> (cons)) \
    else $error("sensor_wrap_unwrap: same-cycle check failed");

// Next-cycle implication, gated off while rst_expr is high.
`define SWU_ASSERT_NXT(label, clk_sig, rst_expr, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_expr) (ante) |=> (cons)) \
    else $error("sensor_wrap_unwrap: next-cycle check failed");

`endif

### sv/swu_pkg.sv
// Shared types and constants of the sensor wrap/unwrap block.
// No dependencies; imported by every swu module.
package swu_pkg;

  localparam int LIMIT_W    = 18;
  localparam int THR_W      = 17;
  localparam int OUT_W      = 20;
  localparam int CH_FIELD_W = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_VALLEY = 2'd1,
    MODE_PEAK   = 2'd2
  } mode_t;

  typedef enum logic {
    CMD_SEED   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_UPPER_XY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_XY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_XY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_Z    = 3'd5;

  typedef struct packed {
    logic signed [LIMIT_W-1:0] upper_xy;
    logic signed [LIMIT_W-1:0] lower_xy;
    logic signed [LIMIT_W-1:0] upper_z;
    logic signed [LIMIT_W-1:0] lower_z;
    logic [THR_W-1:0]          thr_xy;
    logic [THR_W-1:0]          thr_z;
  } limits_t;

  localparam limits_t LIMITS_RESET = '{
    upper_xy: 18'sd65534,
    lower_xy: -18'sd65534,
    upper_z:  18'sd32767,
    lower_z:  -18'sd32767,
    thr_xy:   17'd24000,
    thr_z:    17'd12000
  };

endpackage

### sv/swu_cfg_regs.sv
// Configuration register file: wrap limits and thresholds for XY and Z.
// Depends on swu_pkg.
module swu_cfg_regs
  import swu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output limits_t               limits
);

  always_ff @(posedge clk) begin
    if (rst) begin
      limits <= LIMITS_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_UPPER_XY: limits.upper_xy <= signed'(wr_data[LIMIT_W-1:0]);
        REG_LOWER_XY: limits.lower_xy <= signed'(wr_data[LIMIT_W-1:0]);
        REG_UPPER_Z:  limits.upper_z  <= signed'(wr_data[LIMIT_W-1:0]);
        REG_LOWER_Z:  limits.lower_z  <= signed'(wr_data[LIMIT_W-1:0]);
        REG_THR_XY:   limits.thr_xy   <= wr_data[THR_W-1:0];
        REG_THR_Z:    limits.thr_z    <= wr_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/swu_state_ram.sv
// Per-channel state memory {last raw sample, mode}: one write port, one
// registered read port, clearing sweep after reset, last-write forwarding.
// Depends on swu_pkg.
module swu_state_ram
  import swu_pkg::*;
#(
  parameter int NUM_CHANNELS = 128,
  parameter int SAMPLE_BITS  = 18,
  localparam int AW = $clog2(NUM_CHANNELS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic signed [SAMPLE_BITS-1:0] rd_raw,
  output mode_t                         rd_mode,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] wr_raw,
  input  mode_t                         wr_mode,
  output logic                          busy
);

  localparam int DW = SAMPLE_BITS + 2;

  logic [DW-1:0] mem [NUM_CHANNELS];
  logic [DW-1:0] mem_q;
  logic [AW-1:0] rd_addr_q;
  logic [AW-1:0] clr_addr;
  logic          clearing;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;
  logic          byp_valid;
  logic [AW-1:0] byp_addr;
  logic [DW-1:0] byp_data;
  logic [DW-1:0] rd_word;

  // clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(NUM_CHANNELS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign busy   = clearing;
  assign mem_we = clearing || wr_en;
  assign mem_wa = clearing ? clr_addr : wr_addr;
  assign mem_wd = clearing ? '0 : {wr_raw, wr_mode};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // newest write wins over a read taken at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (wr_en && !clearing) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clearing) begin
      byp_addr <= wr_addr;
      byp_data <= {wr_raw, wr_mode};
    end
  end

  assign rd_word = (byp_valid && byp_addr == rd_addr_q) ? byp_data : mem_q;
  assign rd_raw  = signed'(rd_word[DW-1:2]);
  assign rd_mode = mode_t'(rd_word[1:0]);

endmodule

### sv/swu_unwrap.sv
// Unwrap decision and offset: jump detection, mode update, saturated sum.
// Depends on swu_pkg.
module swu_unwrap
  import swu_pkg::*;
#(
  parameter int SAMPLE_BITS = 18
) (
  input  limits_t                       limits,
  input  cmd_t                          cmd,
  input  logic                          axis_is_z,
  input  logic                          in_range,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] prev_raw,
  input  mode_t                         prev_mode,
  output mode_t                         new_mode,
  output mode_t                         res_mode,
  output logic signed [OUT_W-1:0]       corrected
);

  localparam int BASE_W = (SAMPLE_BITS > LIMIT_W + 1) ? SAMPLE_BITS : LIMIT_W + 1;
  localparam int CW     = BASE_W + 2;

  logic signed [LIMIT_W-1:0] up;
  logic signed [LIMIT_W-1:0] lo;
  logic [THR_W-1:0]          thr;
  logic signed [CW-1:0]      up_x;
  logic signed [CW-1:0]      lo_x;
  logic signed [CW-1:0]      thr_x;
  logic signed [CW-1:0]      cur_x;
  logic signed [CW-1:0]      prev_x;
  logic signed [CW-1:0]      hi_mark;
  logic signed [CW-1:0]      lo_mark;
  logic signed [CW-1:0]      offset;
  logic signed [CW-1:0]      sum;
  logic                      down;
  logic                      rise;
  logic                      sat;
  mode_t                     step_mode;

  assign up  = axis_is_z ? limits.upper_z : limits.upper_xy;
  assign lo  = axis_is_z ? limits.lower_z : limits.lower_xy;
  assign thr = axis_is_z ? limits.thr_z   : limits.thr_xy;

  assign up_x    = CW'(up);
  assign lo_x    = CW'(lo);
  assign thr_x   = CW'(signed'({1'b0, thr}));
  assign cur_x   = CW'(sample);
  assign prev_x  = CW'(prev_raw);
  assign hi_mark = up_x - thr_x;
  assign lo_mark = lo_x + thr_x;

  assign down = (prev_x > hi_mark) && (cur_x < lo_mark);
  assign rise = (prev_x < lo_mark) && (cur_x > hi_mark);

  always_comb begin
    case (prev_mode)
      MODE_NORMAL: begin
        if (down) step_mode = MODE_VALLEY;
        else if (rise) step_mode = MODE_PEAK;
        else step_mode = MODE_NORMAL;
      end
      MODE_VALLEY: begin
        step_mode = rise ? MODE_NORMAL : MODE_VALLEY;
      end
      default: begin
        step_mode = down ? MODE_NORMAL : MODE_PEAK;
      end
    endcase
  end

  assign new_mode = (cmd == CMD_SEED) ? MODE_NORMAL : step_mode;
  assign res_mode = in_range ? new_mode : MODE_NORMAL;

  always_comb begin
    offset = '0;
    if (in_range) begin
      case (new_mode)
        MODE_VALLEY: offset = up_x <<< 1;
        MODE_PEAK:   offset = lo_x <<< 1;
        default:     offset = '0;
      endcase
    end
  end

  assign sum = cur_x + offset;
  assign sat = (sum[CW-1:OUT_W-1] != {(CW - OUT_W + 1){sum[OUT_W-1]}});
  assign corrected = sat ? (sum[CW-1] ? {1'b1, {(OUT_W - 1){1'b0}}}
                                      : {1'b0, {(OUT_W - 1){1'b1}}})
                         : sum[OUT_W-1:0];

endmodule

### sv/sensor_wrap_unwrap.sv
// Pipeline: an accepted item goes to stage s1, then to the result register.
// Throughput: one item per cycle unless result_stall or the sweep holds it;
// state is read from a registered RAM and written back as s1 advances, with
// the last write forwarded. Reset: synchronous; a clearing sweep of all state
// entries follows reset, with item_stall high. Configuration returns to its reset values.
module sensor_wrap_unwrap
  import swu_pkg::*;
#(
  parameter int NUM_CHANNELS = 128,
  parameter int SAMPLE_BITS  = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [CFG_IDX_W-1:0]          wr_index,
  input  logic [CFG_DATA_W-1:0]         wr_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          cmd,
  input  logic [CH_FIELD_W-1:0]         channel,
  input  logic                          axis_is_z,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [OUT_W-1:0]       corrected,
  output logic [1:0]                    mode,
  output logic [CH_FIELD_W-1:0]         echo_channel
);

  localparam int AW = $clog2(NUM_CHANNELS);

  limits_t                       limits;
  logic [31:0]                   ch_ext;
  logic                          in_range;
  logic                          accept;
  logic                          busy;
  logic                          s1_valid;
  logic                          s1_adv;
  cmd_t                          s1_cmd;
  logic [CH_FIELD_W-1:0]         s1_channel;
  logic                          s1_axis;
  logic                          s1_in_range;
  logic [AW-1:0]                 s1_addr;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic signed [SAMPLE_BITS-1:0] prev_raw;
  mode_t                         prev_mode;
  mode_t                         new_mode;
  mode_t                         res_mode;
  logic signed [OUT_W-1:0]       res_corrected;
  logic                          mem_wr;
  mode_t                         out_mode;

  swu_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .limits   (limits)
  );

  assign ch_ext     = 32'(channel);
  assign in_range   = ch_ext < 32'(NUM_CHANNELS);
  assign s1_adv     = !result_valid || !result_stall;
  assign item_stall = busy || (s1_valid && !s1_adv);
  assign accept     = item_valid && !item_stall;
  assign mem_wr     = s1_valid && s1_adv && s1_in_range;

  swu_state_ram #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (ch_ext[AW-1:0]),
    .rd_raw  (prev_raw),
    .rd_mode (prev_mode),
    .wr_en   (mem_wr),
    .wr_addr (s1_addr),
    .wr_raw  (s1_sample),
    .wr_mode (new_mode),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= cmd_t'(cmd);
      s1_channel  <= channel;
      s1_axis     <= axis_is_z;
      s1_in_range <= in_range;
      s1_addr     <= ch_ext[AW-1:0];
      s1_sample   <= sample;
    end
  end

  swu_unwrap #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_unwrap (
    .limits    (limits),
    .cmd       (s1_cmd),
    .axis_is_z (s1_axis),
    .in_range  (s1_in_range),
    .sample    (s1_sample),
    .prev_raw  (prev_raw),
    .prev_mode (prev_mode),
    .new_mode  (new_mode),
    .res_mode  (res_mode),
    .corrected (res_corrected)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      corrected    <= res_corrected;
      out_mode     <= res_mode;
      echo_channel <= s1_channel;
    end
  end

  assign mode = out_mode;

endmodule

### sv/swu_checker.sv
// Port-level checks of sensor_wrap_unwrap and the bind that attaches them.
// Depends on swu_pkg and sensor_wrap_unwrap_assert.svh.
`include "sensor_wrap_unwrap_assert.svh"

module swu_checker
  import swu_pkg::*;
#(
  parameter int NUM_CHANNELS = 128
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    item_valid,
  input logic                    item_stall,
  input logic                    result_valid,
  input logic                    result_stall,
  input logic signed [OUT_W-1:0] corrected,
  input logic [1:0]              mode,
  input logic [CH_FIELD_W-1:0]   echo_channel
);

  `SWU_ASSERT_NXT(a_reset_stalls, clk, 1'b0, rst, item_stall)
  `SWU_ASSERT_IMP(a_result_from_transfer, clk, rst, $rose(result_valid),
                  $past(item_valid && !item_stall, 2))
  `SWU_ASSERT_IMP(a_bad_channel_normal, clk, rst,
                  result_valid && (32'(echo_channel) >= 32'(NUM_CHANNELS)),
                  mode == MODE_NORMAL)
  `SWU_ASSERT_NXT(a_result_holds, clk, rst, result_valid && result_stall,
                  result_valid && $stable(corrected) && $stable(mode) && $stable(echo_channel))

endmodule

bind sensor_wrap_unwrap swu_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_swu_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .corrected    (corrected),
  .mode         (mode),
  .echo_channel (echo_channel)
);
